### design/dd_odo_pkg.sv
// Shared constants, types and the arctangent table for the odometry block.
// No dependencies; the front end, queue, pose engine and top level import this package.
package dd_odo_pkg;

   localparam int CORDIC_ITERATIONS = 24;
   localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;
   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam int GUARD_BITS = 8;
   localparam int SCALE_SHIFT = 31 - GUARD_BITS;
   localparam logic [30:0] CORDIC_K = 31'd1304065748;
   localparam int ACC_W = 42;
   localparam int TRAVEL_W = 50;
   localparam int TURN_W = 33;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_TICKS = 1'b0;
   localparam logic KIND_RELOAD = 1'b1;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_DISTANCE_GAIN = 3'd0;
   localparam csr_index_type CSR_ANGLE_GAIN = 3'd1;
   localparam csr_index_type CSR_START_X = 3'd2;
   localparam csr_index_type CSR_START_Y = 3'd3;
   localparam csr_index_type CSR_START_HEADING = 3'd4;

   localparam logic [31:0] RESET_DISTANCE_GAIN = 32'd451774;
   localparam logic [31:0] RESET_ANGLE_GAIN = 32'd575217;
   localparam logic [31:0] RESET_START_X = 32'd65536;
   localparam logic [31:0] RESET_START_Y = 32'd163840;
   localparam logic [31:0] RESET_START_HEADING = 32'd0;

   typedef struct packed {
      logic [31:0]        distance_gain;
      logic [31:0]        angle_gain;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic [31:0]        start_heading;
   } cfg_type;

   // One classified item on its way from the front end to the pose engine.
   typedef struct packed {
      logic                       reload;
      logic signed [TRAVEL_W-1:0] travel_prod;
      logic [TURN_W-1:0]          turn;
   } job_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCALE,
      S_ROTATE,
      S_FINISH,
      S_DONE
   } back_state_type;

   function automatic logic [29:0] atan_bam(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

### design/dd_odo_if.sv
// Valid/ready channel interfaces for tick requests and pose responses.
// No dependencies.
interface dd_odo_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] left_ticks;
   logic signed [15:0] right_ticks;

   modport source (output valid, output kind, output left_ticks, output right_ticks,
                   input ready);
   modport sink (input valid, input kind, input left_ticks, input right_ticks,
                 output ready);
endinterface

interface dd_odo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pose_x;
   logic signed [31:0] pose_y;
   logic [31:0]        pose_heading;

   modport source (output valid, output pose_x, output pose_y, output pose_heading,
                   input ready);
   modport sink (input valid, input pose_x, input pose_y, input pose_heading,
                 output ready);
endinterface

### design/dd_odo_front.sv
// Front end: takes request transactions, forms travel and turn products, pushes jobs.
// Depends on dd_odo_pkg and dd_odo_req_if.
module dd_odo_front (
   input  logic                clock,
   input  logic                reset,
   input  dd_odo_pkg::cfg_type cfg,
   dd_odo_req_if.sink          req_chan,
   input  logic                queue_full,
   output logic                push,
   output dd_odo_pkg::job_type push_job
);
   import dd_odo_pkg::*;

   logic               stage_valid_ff, stage_valid_in;
   logic               kind_ff;
   logic signed [15:0] left_ff, right_ff;
   logic               accept;
   logic signed [16:0] tick_sum, tick_diff;
   logic signed [TRAVEL_W-1:0] travel_prod, turn_prod;

   assign req_chan.ready = !stage_valid_ff || !queue_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign push = stage_valid_ff && !queue_full;

   assign tick_sum = {left_ff[15], left_ff} + {right_ff[15], right_ff};
   assign tick_diff = {right_ff[15], right_ff} - {left_ff[15], left_ff};
   assign travel_prod = $signed({1'b0, cfg.distance_gain}) * tick_sum;
   assign turn_prod = $signed({1'b0, cfg.angle_gain}) * tick_diff;

   assign push_job.reload = (kind_ff == KIND_RELOAD);
   assign push_job.travel_prod = travel_prod;
   assign push_job.turn = turn_prod[TURN_W-1:0];

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_chan.kind;
         left_ff <= req_chan.left_ticks;
         right_ff <= req_chan.right_ticks;
      end
   end

endmodule

### design/dd_odo_queue.sv
// Short job queue between the front end and the pose engine.
// Depends on dd_odo_pkg.
module dd_odo_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dd_odo_pkg::job_type push_job,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output dd_odo_pkg::job_type pop_job
);
   import dd_odo_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("job queue holds more than its depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("job popped from an empty queue");

endmodule

### design/dd_odo_back.sv
// Pose engine: sequential CORDIC rotation of the travel, pose update and response register.
// Depends on dd_odo_pkg and dd_odo_rsp_if.
module dd_odo_back (
   input  logic                clock,
   input  logic                reset,
   input  dd_odo_pkg::cfg_type cfg,
   input  logic                job_valid,
   input  dd_odo_pkg::job_type job,
   output logic                job_pop,
   dd_odo_rsp_if.source        rsp_chan
);
   import dd_odo_pkg::*;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   back_state_type     state_ff, state_in;
   logic signed [31:0] pos_x_ff, pos_x_in;
   logic signed [31:0] pos_y_ff, pos_y_in;
   logic [31:0]        heading_ff, heading_in;
   logic [31:0]        heading_next_ff, heading_next_in;
   logic signed [31:0] travel_ff, travel_in;
   logic [1:0]         quad_ff, quad_in;
   logic signed [31:0] z_ff, z_in;
   logic signed [ACC_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [STEP_W-1:0]  count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic [31:0]        rsp_heading_ff;
   logic               rsp_load;

   logic signed [33:0] travel_shift;
   logic [31:0]        mid;
   logic [31:0]        mid_round;
   logic signed [63:0] scaled;
   logic signed [ACC_W-1:0] xs, ys;
   logic signed [31:0] atan_step;
   logic signed [33:0] cxg, cyg;
   logic signed [34:0] dx, dy;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pose_x = rsp_x_ff;
   assign rsp_chan.pose_y = rsp_y_ff;
   assign rsp_chan.pose_heading = rsp_heading_ff;

   assign travel_shift = job.travel_prod[TRAVEL_W-1:16];
   assign mid = heading_ff + job.turn[TURN_W-1:1];
   assign mid_round = mid + 32'h2000_0000;
   assign scaled = travel_ff * $signed({1'b0, CORDIC_K});
   assign xs = cx_ff >>> count_ff;
   assign ys = cy_ff >>> count_ff;
   assign atan_step = $signed({2'b00, atan_bam(5'(count_ff))});
   assign cxg = cx_ff[ACC_W-1:GUARD_BITS];
   assign cyg = cy_ff[ACC_W-1:GUARD_BITS];

   always_comb begin
      case (quad_ff)
         2'd0: begin
            dx = 35'(cxg);
            dy = 35'(cyg);
         end
         2'd1: begin
            dx = -35'(cyg);
            dy = 35'(cxg);
         end
         2'd2: begin
            dx = -35'(cxg);
            dy = -35'(cyg);
         end
         default: begin
            dx = 35'(cyg);
            dy = -35'(cxg);
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      heading_in = heading_ff;
      heading_next_in = heading_next_ff;
      travel_in = travel_ff;
      quad_in = quad_ff;
      z_in = z_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      count_in = count_ff;
      job_pop = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               if (job.reload) begin
                  pos_x_in = cfg.start_x;
                  pos_y_in = cfg.start_y;
                  heading_in = cfg.start_heading;
                  state_in = S_DONE;
               end else begin
                  travel_in = sat32(36'(travel_shift));
                  quad_in = mid_round[31:30];
                  z_in = $signed(mid - {mid_round[31:30], 30'd0});
                  heading_next_in = heading_ff + job.turn[31:0];
                  state_in = S_SCALE;
               end
            end
         end
         S_SCALE: begin
            cx_in = ACC_W'($signed(scaled[63:SCALE_SHIFT]));
            cy_in = '0;
            count_in = '0;
            state_in = S_ROTATE;
         end
         S_ROTATE: begin
            if (!z_ff[31]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               z_in = z_ff - atan_step;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               z_in = z_ff + atan_step;
            end
            count_in = count_ff + 1'b1;
            if (count_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            pos_x_in = sat32(36'(pos_x_ff) + 36'(dx));
            pos_y_in = sat32(36'(pos_y_ff) + 36'(dy));
            heading_in = heading_next_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_x_ff <= RESET_START_X;
         pos_y_ff <= RESET_START_Y;
         heading_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         heading_ff <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      heading_next_ff <= heading_next_in;
      travel_ff <= travel_in;
      quad_ff <= quad_in;
      z_ff <= z_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      count_ff <= count_in;
      if (rsp_load) begin
         rsp_x_ff <= pos_x_ff;
         rsp_y_ff <= pos_y_ff;
         rsp_heading_ff <= heading_ff;
      end
   end

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (state_ff == S_IDLE) && job_valid)
      else $error("job taken outside the idle state");
   a_scale_starts_rotation: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCALE) |=> (state_ff == S_ROTATE) && (count_ff == '0))
      else $error("rotation did not start at step zero");
   a_rotate_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROTATE) |-> (count_ff <= STEP_W'(CORDIC_STEPS - 1)))
      else $error("rotation step beyond the iteration count");
   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_valid_ff && !rsp_chan.ready |=> (state_ff == S_DONE))
      else $error("result overwritten while the response register was full");

endmodule

### design/differential_drive_odometry.sv
// Top level of the differential-drive odometry block: registers, front end, queue, pose engine.
// Depends on dd_odo_pkg, dd_odo_if, dd_odo_front, dd_odo_queue and dd_odo_back.
//
// Usage:
//   req_chan carries one transaction per sampling period: kind 0 applies signed left and
//   right encoder tick deltas, kind 1 reloads the pose from start_x, start_y and
//   start_heading. Every request yields exactly one response on rsp_chan: the new pose
//   (Q16.16 x and y, saturated; 32-bit binary-angle heading, wrapping).
//   The csr_ port writes one of the five gain and start registers per write, by csr_index;
//   write them only while no request is in flight.
// Processing steps:
//   A tick update passes the front-end register, where the gain products are formed, the
//   queue, from which the engine takes the job and splits the heading, one scaling
//   multiply, 24 CORDIC steps of the shared shift-add unit, one pose update and the
//   response register. A reload goes from the queue straight to the response register.
//   The engine takes a new job only after its result is in the response register; the
//   front end and queue keep taking requests while the iterative CORDIC loop runs.
// Reset and stalls:
//   Reset clears the handshakes and queue, restores the register defaults and the pose
//   (x 1.0 m, y 2.5 m, heading 0). When the receiver stalls the response is held; the
//   front end, queue and engine still take up to four further requests before req ready drops.
module differential_drive_odometry (
   input  logic                       clock,
   input  logic                       reset,
   dd_odo_req_if.sink                 req_chan,
   dd_odo_rsp_if.source               rsp_chan,
   input  logic                       csr_write_enable,
   input  dd_odo_pkg::csr_index_type  csr_index,
   input  logic [31:0]                csr_write_data
);
   import dd_odo_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push, queue_full, pop, job_valid;
   job_type push_job, pop_job;

   // Register file: decode the index, drop writes beyond the list.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DISTANCE_GAIN: cfg_in.distance_gain = csr_write_data;
            CSR_ANGLE_GAIN:    cfg_in.angle_gain = csr_write_data;
            CSR_START_X:       cfg_in.start_x = csr_write_data;
            CSR_START_Y:       cfg_in.start_y = csr_write_data;
            CSR_START_HEADING: cfg_in.start_heading = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.distance_gain <= RESET_DISTANCE_GAIN;
         cfg_ff.angle_gain <= RESET_ANGLE_GAIN;
         cfg_ff.start_x <= RESET_START_X;
         cfg_ff.start_y <= RESET_START_Y;
         cfg_ff.start_heading <= RESET_START_HEADING;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: hold one request, form the products, advance it into the queue.
   dd_odo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Queue: decouple the front end from the long rotation.
   dd_odo_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (job_valid),
      .pop_job   (pop_job)
   );

   // Pose engine: rotate the travel onto the midpoint heading and update the pose, or reload it.
   dd_odo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job       (pop_job),
      .job_pop   (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
